/* rtl/display_mode_ui_controller_defines.svh */
// assertion macros for the display mode ui controller checker
`ifndef DISPLAY_MODE_UI_CONTROLLER_DEFINES_SVH
`define DISPLAY_MODE_UI_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DMUI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmui check failed");

// next-cycle implication, disabled while in reset
`define DMUI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmui check failed");

`endif

/* rtl/dmui_pkg.sv */
// types, codes and helpers for the display mode ui controller
package dmui_pkg;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_PEAK = 2'd1;
  localparam logic [1:0] REQ_MODE = 2'd2;

  localparam logic [1:0] MODE_TEST   = 2'd0;
  localparam logic [1:0] MODE_RAW    = 2'd1;
  localparam logic [1:0] MODE_NORMAL = 2'd2;
  localparam logic [1:0] MODE_RANGE  = 2'd3;

  localparam logic [1:0] TST_CLEAR = 2'd0;
  localparam logic [1:0] TST_LOW   = 2'd1;
  localparam logic [1:0] TST_HIGH  = 2'd2;

  localparam logic [1:0] NRM_IDLE  = 2'd0;
  localparam logic [1:0] NRM_ENTER = 2'd1;
  localparam logic [1:0] NRM_SHOW  = 2'd2;

  localparam logic [1:0] RNG_IDLE  = 2'd0;
  localparam logic [1:0] RNG_ENTER = 2'd1;
  localparam logic [1:0] RNG_WAIT  = 2'd2;

  localparam logic [1:0] REG_TEST_STEP = 2'd0;
  localparam logic [1:0] REG_CHASER    = 2'd1;
  localparam logic [1:0] REG_RANGE_TO  = 2'd2;

  localparam logic [15:0] BLANK_PAIR    = 16'h1010;
  localparam logic [15:0] LETTER_R_HIGH = 16'h1400;
  localparam logic [3:0]  CHASER_LOAD   = 4'h8;
  localparam logic [3:0]  CHASER_START  = 4'hF;
  localparam logic [1:0]  BTN_UP        = 2'b10;
  localparam logic [1:0]  BTN_DN        = 2'b01;
  localparam logic [3:0]  LAST_DIGIT    = 4'd9;
  localparam logic [2:0]  RANGE_MAX     = 3'd4;
  localparam logic [2:0]  RANGE_MIN     = 3'd1;

  typedef struct packed {
    logic [7:0] test_step_delay;
    logic [7:0] chaser_delay;
    logic [7:0] range_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] buttons;
    logic [8:0] peak_value;
    logic [1:0] new_mode;
  } req_t;

  typedef struct packed {
    logic [1:0] ui_mode;
    logic [1:0] test_phase;
    logic [7:0] step_wait;
    logic [3:0] digit_count;
    logic [1:0] normal_phase;
    logic [7:0] chaser_wait;
    logic [3:0] chaser_bits;
    logic [2:0] range_level;
    logic [1:0] range_phase;
    logic [7:0] range_wait;
    logic       button_held;
    logic [8:0] peak_raw;
    logic [3:0] peak_tens;
    logic [3:0] peak_ones;
  } state_t;

  typedef struct packed {
    logic        display_write;
    logic [15:0] display_value;
    logic        set_digit_mode;
    logic        points_write;
    logic [3:0]  points_pattern;
    logic        range_write;
    logic [2:0]  range_out;
    logic        sensor_init;
  } res_t;

  // percent = (peak*25)>>7, at most 99; returns {tens, ones}
  function automatic logic [7:0] peak_to_bcd(input logic [8:0] peak);
    logic [13:0] prod;
    logic [6:0]  pct;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    prod = {1'b0, peak, 4'b0} + {2'b0, peak, 3'b0} + {5'b0, peak};
    pct  = prod[13:7];
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (pct >= 7'(10 * k)) tens = 4'(k);
    end
    tens_x10 = {tens[3:0], 3'b0} + {2'b0, tens[3:0], 1'b0};
    ones     = pct - tens_x10;
    return {tens, ones[3:0]};
  endfunction

endpackage

/* rtl/display_mode_ui_controller.sv */
// top level of the two-digit display mode ui controller
// Takes one request per clock (tick with button scan, store peak, force mode) while not
// stalled, and returns exactly one result per request. Each request is first captured in an
// input register; the next state and the result are computed from that register and the mode
// state in a single combinational pass and land in a result register, so each result passes
// through the input register and then the result register. The result register decouples
// the sides: a new request is taken while a finished result still waits, and the input
// stalls only when both registers are full and out_stall is high. Configuration
// registers sit on an APB-style port at byte addresses 0, 4 and 8 (test step delay,
// chaser delay, range timeout; low 8 bits used) and should only be written while no
// request is in flight. Chaser delay and range timeout are 8-bit down counters that wrap,
// so a delay of zero waits 256 ticks; a test step delay of zero adds no wait.
module display_mode_ui_controller import dmui_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_buttons,
  input  logic [8:0]  in_peak_value,
  input  logic [1:0]  in_new_mode,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_display_write,
  output logic [15:0] out_display_value,
  output logic        out_set_digit_mode,
  output logic        out_points_write,
  output logic [3:0]  out_points_pattern,
  output logic        out_range_write,
  output logic [2:0]  out_range_out,
  output logic        out_sensor_init,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg_r;
  req_t   req_r;
  logic   req_valid_r;
  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;
  logic   out_valid_r;

  logic   in_take;
  logic   out_free;
  logic   advance;
  logic   cfg_wr;
  logic [1:0] reg_idx;

  // input register moves on when the result register is empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // register read back, zero beyond the last register
  always_comb begin
    case (reg_idx)
      REG_TEST_STEP: prdata = {24'h000000, cfg_r.test_step_delay};
      REG_CHASER:    prdata = {24'h000000, cfg_r.chaser_delay};
      REG_RANGE_TO:  prdata = {24'h000000, cfg_r.range_timeout};
      default:       prdata = 32'h00000000;
    endcase
  end

  // mode logic for the request held in the input register
  dmui_step u_step (
    .cfg    (cfg_r),
    .rq     (req_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // control state, configuration and mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{test_step_delay: 8'd2, chaser_delay: 8'd10, range_timeout: 8'd30};
      state_r     <= '{ui_mode: MODE_TEST, range_level: RANGE_MIN, default: '0};
    end else begin
      if (in_take) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (reg_idx)
          REG_TEST_STEP: cfg_r.test_step_delay <= pwdata[7:0];
          REG_CHASER:    cfg_r.chaser_delay    <= pwdata[7:0];
          REG_RANGE_TO:  cfg_r.range_timeout   <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.req_type   <= in_req_type;
      req_r.buttons    <= in_buttons;
      req_r.peak_value <= in_peak_value;
      req_r.new_mode   <= in_new_mode;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_display_write  = res_r.display_write;
  assign out_display_value  = res_r.display_value;
  assign out_set_digit_mode = res_r.set_digit_mode;
  assign out_points_write   = res_r.points_write;
  assign out_points_pattern = res_r.points_pattern;
  assign out_range_write    = res_r.range_write;
  assign out_range_out      = res_r.range_out;
  assign out_sensor_init    = res_r.sensor_init;

endmodule

/* rtl/dmui_step.sv */
// next state and result for one request
module dmui_step import dmui_pkg::*; (
  input  cfg_t   cfg,
  input  req_t   rq,
  input  state_t st,
  output state_t st_nxt,
  output res_t   res
);

  always_comb begin
    logic [3:0] dig;
    logic [7:0] rwait;
    logic [7:0] cwait;
    logic [7:0] bcd;
    st_nxt = st;
    res    = '0;
    dig    = 4'd0;
    rwait  = 8'd0;
    cwait  = 8'd0;
    bcd    = peak_to_bcd(rq.peak_value);
    case (rq.req_type)
      REQ_PEAK: begin
        st_nxt.peak_raw  = rq.peak_value;
        st_nxt.peak_tens = bcd[7:4];
        st_nxt.peak_ones = bcd[3:0];
      end
      REQ_MODE: begin
        st_nxt.ui_mode = rq.new_mode;
      end
      REQ_TICK: begin
        case (st.ui_mode)
          MODE_TEST: begin
            if (st.step_wait != 8'd0) begin
              st_nxt.step_wait = st.step_wait - 8'd1;
            end else begin
              case (st.test_phase)
                TST_CLEAR: begin
                  st_nxt.digit_count = 4'd0;
                  res.display_write  = 1'b1;
                  res.set_digit_mode = 1'b1;
                  st_nxt.test_phase  = TST_LOW;
                  st_nxt.step_wait   = cfg.test_step_delay;
                end
                TST_LOW: begin
                  dig = st.digit_count + 4'd1;
                  if (dig > LAST_DIGIT) begin
                    st_nxt.test_phase = TST_HIGH;
                    dig = 4'd0;
                  end
                  st_nxt.digit_count = dig;
                  res.display_write  = 1'b1;
                  res.display_value  = {12'h000, dig};
                  st_nxt.step_wait   = cfg.test_step_delay;
                end
                TST_HIGH: begin
                  dig = st.digit_count + 4'd1;
                  if (dig <= LAST_DIGIT) begin
                    res.display_write = 1'b1;
                    res.display_value = {4'h0, dig, 8'h00};
                  end else begin
                    st_nxt.test_phase   = TST_CLEAR;
                    st_nxt.ui_mode      = MODE_NORMAL;
                    st_nxt.normal_phase = NRM_ENTER;
                    st_nxt.chaser_bits  = CHASER_START;
                    res.sensor_init     = 1'b1;
                  end
                  st_nxt.digit_count = dig;
                  st_nxt.step_wait   = cfg.test_step_delay;
                end
                default: begin
                  st_nxt.test_phase = TST_CLEAR;
                end
              endcase
            end
          end
          MODE_NORMAL: begin
            case (st.normal_phase)
              NRM_ENTER: begin
                res.set_digit_mode  = 1'b1;
                res.display_write   = 1'b1;
                res.display_value   = BLANK_PAIR;
                res.points_write    = 1'b1;
                st_nxt.chaser_wait  = cfg.chaser_delay;
                st_nxt.normal_phase = NRM_SHOW;
              end
              NRM_SHOW: begin
                res.display_write = 1'b1;
                res.display_value = (st.peak_raw != 9'd0) ?
                                    {4'h0, st.peak_tens, 4'h0, st.peak_ones} : BLANK_PAIR;
              end
              default: ;
            endcase
          end
          MODE_RANGE: begin
            case (st.range_phase)
              RNG_ENTER: begin
                res.display_write  = 1'b1;
                res.display_value  = LETTER_R_HIGH | {13'h0000, st.range_level};
                st_nxt.range_wait  = cfg.range_timeout;
                st_nxt.range_phase = RNG_WAIT;
              end
              RNG_WAIT: begin
                rwait = st.range_wait - 8'd1;
                st_nxt.range_wait = rwait;
                if (rwait == 8'd0) begin
                  st_nxt.ui_mode      = MODE_NORMAL;
                  st_nxt.normal_phase = NRM_ENTER;
                  st_nxt.peak_raw     = 9'd0;
                  st_nxt.peak_tens    = 4'd0;
                  st_nxt.peak_ones    = 4'd0;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase

        // decimal point chaser
        cwait = st_nxt.chaser_wait - 8'd1;
        if (cwait == 8'd0) begin
          st_nxt.chaser_bits = (st_nxt.chaser_bits != 4'd0) ?
                               (st_nxt.chaser_bits >> 1) : CHASER_LOAD;
          res.points_write = 1'b1;
          cwait = cfg.chaser_delay;
        end
        st_nxt.chaser_wait = cwait;

        // button scan
        if (rq.buttons == 2'b00) begin
          st_nxt.button_held = 1'b0;
        end else if (!st.button_held && (rq.buttons inside {BTN_UP, BTN_DN})) begin
          if (st_nxt.ui_mode == MODE_RANGE) begin
            if (rq.buttons == BTN_UP && st.range_level < RANGE_MAX) begin
              st_nxt.range_level = st.range_level + 3'd1;
              res.range_write    = 1'b1;
            end else if (rq.buttons == BTN_DN && st.range_level > RANGE_MIN) begin
              st_nxt.range_level = st.range_level - 3'd1;
              res.range_write    = 1'b1;
            end
          end
          st_nxt.button_held = 1'b1;
          st_nxt.ui_mode     = MODE_RANGE;
          st_nxt.range_phase = RNG_ENTER;
        end
      end
      default: ;
    endcase
    res.points_pattern = st_nxt.chaser_bits;
    res.range_out      = st_nxt.range_level;
  end

endmodule

/* rtl/dmui_checker.sv */
// port-level checks for the display mode ui controller, bound to the top level
`include "display_mode_ui_controller_defines.svh"

module dmui_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_display_write,
  input logic [15:0] out_display_value,
  input logic        out_set_digit_mode,
  input logic [3:0]  out_points_pattern,
  input logic [2:0]  out_range_out,
  input logic        out_sensor_init
);

  // a stalled result keeps its valid and payload
  `DMUI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_display_value) && $stable(out_points_pattern) && $stable(out_range_out))

  // display value is zero unless it is written
  `DMUI_ASSERT_NOW(a_disp_zero, clk, rst_n, out_valid && !out_display_write,
    out_display_value == 16'h0000)

  // range level stays between one and four
  `DMUI_ASSERT_NOW(a_range_bounds, clk, rst_n, out_valid,
    out_range_out == 3'd1 || out_range_out == 3'd2 || out_range_out == 3'd3 ||
    out_range_out == 3'd4)

  // digit mode only comes with a display write, sensor init never does
  `DMUI_ASSERT_NOW(a_flag_mix, clk, rst_n, out_valid && (out_set_digit_mode || out_sensor_init),
    out_display_write != out_sensor_init && !(out_set_digit_mode && out_sensor_init))

endmodule

bind display_mode_ui_controller dmui_checker u_dmui_checker (.*);

/* dv/tb_display_mode_ui_controller.sv */
// self-checking testbench for the display mode ui controller: random traffic, live prediction
module tb_display_mode_ui_controller;
  import dmui_pkg::*;

  // request type with no meaning, the block answers it with no writes, only points pattern and range level
  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam logic [1:0] BTN_NONE    = 2'b00;
  localparam logic [1:0] BTN_BOTH    = 2'b11;
  // byte address of a register slot past the last one, writes there are dropped
  localparam logic [3:0] ADDR_UNUSED = 4'd12;
  localparam int         MAX_LINES   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_TICK;
  logic [1:0]  in_buttons = BTN_NONE;
  logic [8:0]  in_peak_value = 9'd0;
  logic [1:0]  in_new_mode = MODE_TEST;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_display_write;
  logic [15:0] out_display_value;
  logic        out_set_digit_mode;
  logic        out_points_write;
  logic [3:0]  out_points_pattern;
  logic        out_range_write;
  logic [2:0]  out_range_out;
  logic        out_sensor_init;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // requests waiting to be driven, and results the block still owes us
  req_t        req_backlog[$];
  res_t        ui_results_due[$];
  req_t        cur_req;
  res_t        due_res;
  int          send_hold = 0;
  int          stall_left = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int          mismatches = 0;

  // our own copy of the controller state, reset values
  cfg_t        ui_cfg = '{test_step_delay: 8'd2, chaser_delay: 8'd10, range_timeout: 8'd30};
  logic [1:0]  mode_q = MODE_TEST;
  logic [1:0]  tphase = TST_CLEAR;
  logic [7:0]  step_cnt = 8'd0;
  logic [3:0]  digit = 4'd0;
  logic [1:0]  nphase = NRM_IDLE;
  logic [7:0]  chase_cnt = 8'd0;
  logic [3:0]  chase_bits = 4'd0;
  logic [2:0]  rlevel = 3'd1;
  logic [1:0]  rphase = RNG_IDLE;
  logic [7:0]  rcount = 8'd0;
  logic        btn_latched = 1'b0;
  logic [8:0]  peak_mag = 9'd0;
  logic [15:0] peak_digits = 16'd0;

  display_mode_ui_controller DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_buttons, .in_peak_value, .in_new_mode,
    .out_valid, .out_stall, .out_display_write, .out_display_value,
    .out_set_digit_mode, .out_points_write, .out_points_pattern,
    .out_range_write, .out_range_out, .out_sensor_init,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // store a peak and its two-digit percent, tens in the high byte
  function automatic void latch_peak(input logic [8:0] mag);
    int pct;
    pct = (int'(mag) * 25) >> 7;
    peak_mag = mag;
    peak_digits = {4'd0, 4'(pct / 10), 4'd0, 4'(pct % 10)};
  endfunction

  // advance the controller by one request and return the result it must give
  function automatic res_t advance_ui(input req_t rq);
    res_t r;
    r = '0;
    case (rq.req_type)
      REQ_PEAK: latch_peak(rq.peak_value);
      REQ_MODE: mode_q = rq.new_mode;
      REQ_TICK: begin
        case (mode_q)
          MODE_TEST: begin
            // self test walks 0..9 on the low digit, then on the high digit
            if (step_cnt != 8'd0) begin
              step_cnt = step_cnt - 8'd1;
            end else begin
              case (tphase)
                TST_CLEAR: begin
                  digit = 4'd0;
                  r.display_write = 1'b1;
                  r.display_value = 16'd0;
                  r.set_digit_mode = 1'b1;
                  tphase = TST_LOW;
                  step_cnt = ui_cfg.test_step_delay;
                end
                TST_LOW: begin
                  digit = digit + 4'd1;
                  if (digit > LAST_DIGIT) begin
                    tphase = TST_HIGH;
                    digit = 4'd0;
                  end
                  r.display_write = 1'b1;
                  r.display_value = {12'd0, digit};
                  step_cnt = ui_cfg.test_step_delay;
                end
                TST_HIGH: begin
                  digit = digit + 4'd1;
                  if (digit <= LAST_DIGIT) begin
                    r.display_write = 1'b1;
                    r.display_value = {4'd0, digit, 8'd0};
                  end else begin
                    // test done: go to normal and ask for a sensor init
                    tphase = TST_CLEAR;
                    mode_q = MODE_NORMAL;
                    nphase = NRM_ENTER;
                    chase_bits = CHASER_START;
                    r.sensor_init = 1'b1;
                  end
                  step_cnt = ui_cfg.test_step_delay;
                end
                default: tphase = TST_CLEAR;
              endcase
            end
          end
          MODE_NORMAL: begin
            if (nphase == NRM_ENTER) begin
              r.set_digit_mode = 1'b1;
              r.display_write = 1'b1;
              r.display_value = BLANK_PAIR;
              r.points_write = 1'b1;
              chase_cnt = ui_cfg.chaser_delay;
              nphase = NRM_SHOW;
            end else if (nphase == NRM_SHOW) begin
              r.display_write = 1'b1;
              r.display_value = (peak_mag != 9'd0) ? peak_digits : BLANK_PAIR;
            end
          end
          MODE_RANGE: begin
            if (rphase == RNG_ENTER) begin
              r.display_write = 1'b1;
              r.display_value = LETTER_R_HIGH | {13'd0, rlevel};
              rcount = ui_cfg.range_timeout;
              rphase = RNG_WAIT;
            end else if (rphase == RNG_WAIT) begin
              rcount = rcount - 8'd1;
              if (rcount == 8'd0) begin
                mode_q = MODE_NORMAL;
                nphase = NRM_ENTER;
                latch_peak(9'd0);
              end
            end
          end
          default: ;
        endcase

        // decimal point chaser runs on every tick, wrapping 8-bit counter
        chase_cnt = chase_cnt - 8'd1;
        if (chase_cnt == 8'd0) begin
          chase_bits = (chase_bits != 4'd0) ? (chase_bits >> 1) : CHASER_LOAD;
          r.points_write = 1'b1;
          chase_cnt = ui_cfg.chaser_delay;
        end

        // one action per press, both buttons together do nothing
        if (rq.buttons == BTN_NONE) begin
          btn_latched = 1'b0;
        end else if (!btn_latched && (rq.buttons == BTN_UP || rq.buttons == BTN_DN)) begin
          if (mode_q == MODE_RANGE) begin
            if (rq.buttons == BTN_UP && rlevel < RANGE_MAX) begin
              rlevel = rlevel + 3'd1;
              r.range_write = 1'b1;
            end else if (rq.buttons == BTN_DN && rlevel > RANGE_MIN) begin
              rlevel = rlevel - 3'd1;
              r.range_write = 1'b1;
            end
          end
          btn_latched = 1'b1;
          mode_q = MODE_RANGE;
          rphase = RNG_ENTER;
        end
      end
      default: ;
    endcase
    r.points_pattern = chase_bits;
    r.range_out = rlevel;
    return r;
  endfunction

  // back to back when calm, else mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int pick_idle(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_req(input logic [1:0] kind, input logic [1:0] btn,
                                  input logic [8:0] mag, input logic [1:0] mode);
    req_t rq;
    rq.req_type = kind;
    rq.buttons = btn;
    rq.peak_value = mag;
    rq.new_mode = mode;
    req_backlog.push_back(rq);
  endfunction

  // mostly ticks with occasional presses, plus peak stores, mode forcing and junk
  function automatic req_t random_req(input int btn_pct);
    req_t rq;
    int roll;
    rq.buttons = 2'($urandom_range(0, 3));
    rq.peak_value = 9'($urandom_range(0, 511));
    rq.new_mode = 2'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      rq.req_type = REQ_MODE;
    end else if (roll < 5) begin
      rq.req_type = REQ_NONE;
    end else if (roll < 15) begin
      rq.req_type = REQ_PEAK;
      roll = $urandom_range(0, 9);
      if (roll == 0) rq.peak_value = 9'd0;
      else if (roll == 1) rq.peak_value = 9'd511;
    end else begin
      rq.req_type = REQ_TICK;
      rq.buttons = BTN_NONE;
      if ($urandom_range(0, 99) < btn_pct) begin
        roll = $urandom_range(0, 9);
        rq.buttons = (roll < 5) ? BTN_UP : (roll < 9) ? BTN_DN : BTN_BOTH;
      end
    end
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    // keep the log short when everything goes wrong, but count every one
    if (mismatches < MAX_LINES)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic cfg_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr[3:2])
      REG_TEST_STEP: ui_cfg.test_step_delay = data[7:0];
      REG_CHASER:    ui_cfg.chaser_delay = data[7:0];
      REG_RANGE_TO:  ui_cfg.range_timeout = data[7:0];
      default: ;
    endcase
  endtask

  // sender holds off until every request has been answered
  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || ui_results_due.size() != 0);
    // then let the result register settle behind the last result
    repeat (4) @(negedge clk);
  endtask

  // one configuration setting: a clean self-test run first, then random traffic
  task automatic run_phase(input logic [7:0] tsd, input logic [7:0] cd,
                           input logic [7:0] rt, input int n_items, input int btn_pct,
                           input bit s_calm, input bit r_calm);
    int clean;
    cfg_write({REG_TEST_STEP, 2'b00}, {24'($urandom_range(0, 16777215)), tsd});
    cfg_write({REG_CHASER, 2'b00}, {24'($urandom_range(0, 16777215)), cd});
    cfg_write({REG_RANGE_TO, 2'b00}, {24'($urandom_range(0, 16777215)), rt});
    @(negedge clk);
    send_calm = s_calm;
    recv_calm = r_calm;
    // enough button-free ticks for a full self test when the step delay is short
    clean = 21 * (int'(tsd) + 1) + 3;
    if (clean > 70) clean = 70;
    add_req(REQ_MODE, BTN_NONE, 9'd0, MODE_TEST);
    repeat (clean) add_req(REQ_TICK, BTN_NONE, 9'($urandom_range(0, 511)), MODE_TEST);
    repeat (n_items - clean - 1) req_backlog.push_back(random_req(btn_pct));
    wait_drained();
  endtask

  // driver: present the next request once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ui_results_due.push_back(advance_ui(cur_req));
      end
      if (!in_valid || !in_stall) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          in_req_type <= cur_req.req_type;
          in_buttons <= cur_req.buttons;
          in_peak_value <= cur_req.peak_value;
          in_new_mode <= cur_req.new_mode;
          in_valid <= 1'b1;
          send_hold = pick_idle(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest one due, then pick the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (ui_results_due.size() == 0) begin
          report_mismatch("result with nothing due, display_value", out_display_value, 0);
        end else begin
          due_res = ui_results_due.pop_front();
          check_field("display_write", out_display_write, due_res.display_write);
          check_field("display_value", out_display_value, due_res.display_value);
          check_field("set_digit_mode", out_set_digit_mode, due_res.set_digit_mode);
          check_field("points_write", out_points_write, due_res.points_write);
          check_field("points_pattern", out_points_pattern, due_res.points_pattern);
          check_field("range_write", out_range_write, due_res.range_write);
          check_field("range_out", out_range_out, due_res.range_out);
          check_field("sensor_init", out_sensor_init, due_res.sensor_init);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle(recv_calm);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: junk request type, modes forced with their phases still idle
    add_req(REQ_NONE, BTN_BOTH, 9'd511, MODE_RANGE);
    add_req(REQ_MODE, BTN_NONE, 9'd0, MODE_RANGE);
    add_req(REQ_TICK, BTN_NONE, 9'd0, MODE_TEST);
    add_req(REQ_MODE, BTN_NONE, 9'd0, MODE_NORMAL);
    add_req(REQ_TICK, BTN_NONE, 9'd0, MODE_TEST);
    add_req(REQ_MODE, BTN_NONE, 9'd0, MODE_RAW);
    add_req(REQ_TICK, BTN_NONE, 9'd0, MODE_TEST);
    // peak extremes
    add_req(REQ_PEAK, BTN_NONE, 9'd511, MODE_TEST);
    add_req(REQ_PEAK, BTN_NONE, 9'd0, MODE_TEST);
    add_req(REQ_PEAK, BTN_NONE, 9'd128, MODE_TEST);
    // both buttons ignored, then walk the range level up past its top
    add_req(REQ_MODE, BTN_NONE, 9'd0, MODE_TEST);
    add_req(REQ_TICK, BTN_BOTH, 9'd0, MODE_TEST);
    add_req(REQ_TICK, BTN_UP, 9'd0, MODE_TEST);
    add_req(REQ_TICK, BTN_NONE, 9'd0, MODE_TEST);
    repeat (4) begin
      add_req(REQ_TICK, BTN_UP, 9'd0, MODE_TEST);
      add_req(REQ_TICK, BTN_NONE, 9'd0, MODE_TEST);
    end
    // held button does not repeat
    add_req(REQ_TICK, BTN_DN, 9'd0, MODE_TEST);
    add_req(REQ_TICK, BTN_DN, 9'd0, MODE_TEST);
    add_req(REQ_TICK, BTN_NONE, 9'd0, MODE_TEST);
    wait_drained();

    // writes past the last register are dropped
    cfg_write(ADDR_UNUSED, 32'hFFFF_FFFF);

    // reset values, then the extremes, then a few in between
    run_phase(8'd2, 8'd10, 8'd30, 150, 8, 1'b0, 1'b0);
    run_phase(8'd0, 8'd1, 8'd1, 120, 15, 1'b1, 1'b1);
    run_phase(8'd255, 8'd255, 8'd255, 100, 5, 1'b0, 1'b0);
    run_phase(8'd5, 8'd3, 8'd12, 150, 10, 1'b0, 1'b1);
    run_phase(8'd1, 8'd2, 8'd4, 130, 20, 1'b0, 1'b0);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
